@@ hdl/i2cmbe_pkg.sv @@
// Shared types, codes and helpers for the I2C master bit engine.
`default_nettype none
package i2cmbe_pkg;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_WACK  = 3'd5;

  localparam logic [0:0] REG_TICKS_PER_US = 1'd0;
  localparam logic [0:0] REG_ACK_TIMEOUT  = 1'd1;

  localparam logic [9:0]  TPU_RESET = 10'd100;
  localparam logic [15:0] TMO_RESET = 16'd250;

  // delay unit multipliers as shift amounts
  localparam logic [1:0] SH_1 = 2'd0;
  localparam logic [1:0] SH_2 = 2'd1;
  localparam logic [1:0] SH_4 = 2'd2;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_WACK  = 3'd5
  } cmd_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_ST_A   = 5'd1,
    PH_ST_B   = 5'd2,
    PH_SP_A   = 5'd3,
    PH_SP_B   = 5'd4,
    PH_W_LOW  = 5'd5,
    PH_W_HIGH = 5'd6,
    PH_W_TAIL = 5'd7,
    PH_R_LOW  = 5'd8,
    PH_R_HIGH = 5'd9,
    PH_A_LOW  = 5'd10,
    PH_A_HIGH = 5'd11,
    PH_K_PRE  = 5'd12,
    PH_K_HIGH = 5'd13,
    PH_K_POLL = 5'd14
  } phase_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx;
    logic       ack;
    logic       sda;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } fe2be_t;

  function automatic logic [12:0] dly_load(input logic [9:0] tpu, input logic [1:0] sh);
    logic [9:0] t;
    t = (tpu == 10'd0) ? 10'd1 : tpu;
    return {3'b000, t} << sh;
  endfunction

endpackage
`default_nettype wire

@@ hdl/i2cmbe_ifs.sv @@
// Valid/ready channel interfaces for the input ticks and the results.
`default_nettype none
interface i2cmbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] tx_byte;
  logic       ack_after_read;
  logic       sda_in;

  modport source (output valid, op, tx_byte, ack_after_read, sda_in, input ready);
  modport sink (input valid, op, tx_byte, ack_after_read, sda_in, output ready);
endinterface

interface i2cmbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       no_ack;
  logic       cmd_rejected;

  modport source (output valid, scl_out, sda_out, sda_drive, busy_res, done_res, rx_byte,
                  no_ack, cmd_rejected, input ready);
  modport sink (input valid, scl_out, sda_out, sda_drive, busy_res, done_res, rx_byte,
                no_ack, cmd_rejected, output ready);
endinterface
`default_nettype wire

@@ hdl/i2cmbe_front.sv @@
// Front end: decode the op of each tick and hold it in a two-entry queue.
`default_nettype none
module i2cmbe_front (
  input  logic                clk,
  input  logic                rst_n,
  i2cmbe_in_if.sink           in_ch,
  output i2cmbe_pkg::fe2be_t  q_head,
  input  logic                q_pop
);
  import i2cmbe_pkg::*;

  localparam int unsigned DEPTH = 2;

  item_t       mem_r [DEPTH];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  item_t       item_in;

  always_comb begin
    item_in.tx  = in_ch.tx_byte;
    item_in.ack = in_ch.ack_after_read;
    item_in.sda = in_ch.sda_in;
    unique case (in_ch.op)
      OP_START: item_in.cmd = CMD_START;
      OP_STOP:  item_in.cmd = CMD_STOP;
      OP_WRITE: item_in.cmd = CMD_WRITE;
      OP_READ:  item_in.cmd = CMD_READ;
      OP_WACK:  item_in.cmd = CMD_WACK;
      default:  item_in.cmd = CMD_NONE;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule
`default_nettype wire

@@ hdl/i2cmbe_back.sv @@
// Back end: bus sequencer, delay timing, config registers and result register.
`default_nettype none
module i2cmbe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  i2cmbe_pkg::fe2be_t  q_head,
  output logic                q_pop,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  i2cmbe_out_if.source        out_ch
);
  import i2cmbe_pkg::*;

  logic [9:0]  tpu_r;
  logic [15:0] tmo_r;

  phase_t      phase_r, phase_nxt;
  logic [12:0] dly_r, dly_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  shf_r, shf_nxt;
  logic [15:0] poll_r, poll_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        drv_r, drv_nxt;
  logic        rack_r, rack_nxt;
  logic [7:0]  rx_r, rx_nxt;
  logic        nack_r, nack_nxt;
  logic        done_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_busy_r, out_done_r, out_rej_r;

  logic        step_en;
  logic        is_idle;
  logic        is_poll;
  logic        tick_down;
  logic        timed_out;
  logic        rej_nxt;
  logic [3:0]  bit_inc;
  logic        last_bit;
  item_t       it;

  assign it        = q_head.item;
  assign step_en   = q_head.valid && (!out_valid_r || out_ch.ready);
  assign q_pop     = step_en;
  assign is_idle   = (phase_r == PH_IDLE);
  assign is_poll   = (phase_r == PH_K_POLL);
  assign tick_down = (dly_r > 13'd1);
  assign timed_out = (poll_r >= tmo_r);
  assign bit_inc   = bit_r + 4'd1;
  assign last_bit  = (bit_inc >= BITS_PER_BYTE);
  assign rej_nxt   = !is_idle && (it.cmd != CMD_NONE);

  always_comb begin : next_phase
    phase_nxt = phase_r;
    dly_nxt   = dly_r;
    done_nxt  = 1'b0;
    if (is_idle) begin
      unique case (it.cmd)
        CMD_START: begin phase_nxt = PH_ST_A;  dly_nxt = dly_load(tpu_r, SH_4); end
        CMD_STOP:  begin phase_nxt = PH_SP_A;  dly_nxt = dly_load(tpu_r, SH_4); end
        CMD_WRITE: begin phase_nxt = PH_W_LOW; dly_nxt = dly_load(tpu_r, SH_2); end
        CMD_READ:  begin phase_nxt = PH_R_LOW; dly_nxt = dly_load(tpu_r, SH_2); end
        CMD_WACK:  begin phase_nxt = PH_K_PRE; dly_nxt = dly_load(tpu_r, SH_1); end
        default: ;
      endcase
    end else if (is_poll) begin
      if (!it.sda) begin
        phase_nxt = PH_IDLE;
        dly_nxt   = 13'd0;
        done_nxt  = 1'b1;
      end else if (timed_out) begin
        phase_nxt = PH_SP_A;
        dly_nxt   = dly_load(tpu_r, SH_4);
      end
    end else if (tick_down) begin
      dly_nxt = dly_r - 13'd1;
    end else begin
      unique case (phase_r)
        PH_ST_A:   begin phase_nxt = PH_ST_B;   dly_nxt = dly_load(tpu_r, SH_4); end
        PH_SP_A:   begin phase_nxt = PH_SP_B;   dly_nxt = dly_load(tpu_r, SH_4); end
        PH_W_LOW:  begin phase_nxt = PH_W_HIGH; dly_nxt = dly_load(tpu_r, SH_2); end
        PH_W_HIGH: begin phase_nxt = PH_W_TAIL; dly_nxt = dly_load(tpu_r, SH_2); end
        PH_W_TAIL: begin
          if (last_bit) begin
            phase_nxt = PH_IDLE; dly_nxt = 13'd0; done_nxt = 1'b1;
          end else begin
            phase_nxt = PH_W_LOW; dly_nxt = dly_load(tpu_r, SH_2);
          end
        end
        PH_R_LOW:  begin phase_nxt = PH_R_HIGH; dly_nxt = dly_load(tpu_r, SH_1); end
        PH_R_HIGH: begin
          phase_nxt = last_bit ? PH_A_LOW : PH_R_LOW;
          dly_nxt   = dly_load(tpu_r, SH_2);
        end
        PH_A_LOW:  begin phase_nxt = PH_A_HIGH; dly_nxt = dly_load(tpu_r, SH_2); end
        PH_K_PRE:  begin phase_nxt = PH_K_HIGH; dly_nxt = dly_load(tpu_r, SH_1); end
        PH_K_HIGH: begin phase_nxt = PH_K_POLL; dly_nxt = 13'd0; end
        default:   begin phase_nxt = PH_IDLE;   dly_nxt = 13'd0; done_nxt = 1'b1; end
      endcase
    end
  end

  always_comb begin : line_outputs
    scl_nxt  = scl_r;
    sda_nxt  = sda_r;
    drv_nxt  = drv_r;
    bit_nxt  = bit_r;
    shf_nxt  = shf_r;
    poll_nxt = poll_r;
    rack_nxt = rack_r;
    rx_nxt   = rx_r;
    nack_nxt = nack_r;
    if (is_idle) begin
      unique case (it.cmd)
        CMD_START: begin drv_nxt = 1'b1; sda_nxt = 1'b1; scl_nxt = 1'b1; end
        CMD_STOP:  begin drv_nxt = 1'b1; sda_nxt = 1'b0; scl_nxt = 1'b0; end
        CMD_WRITE: begin
          drv_nxt = 1'b1;
          scl_nxt = 1'b0;
          bit_nxt = 4'd0;
          sda_nxt = it.tx[7];
          shf_nxt = {it.tx[6:0], 1'b0};
        end
        CMD_READ: begin
          drv_nxt  = 1'b0;
          scl_nxt  = 1'b0;
          bit_nxt  = 4'd0;
          shf_nxt  = 8'd0;
          rack_nxt = it.ack;
        end
        CMD_WACK: begin drv_nxt = 1'b0; sda_nxt = 1'b1; nack_nxt = 1'b0; end
        default: ;
      endcase
    end else if (is_poll) begin
      if (!it.sda) begin
        scl_nxt = 1'b0;
      end else if (timed_out) begin
        nack_nxt = 1'b1;
        drv_nxt  = 1'b1;
        scl_nxt  = 1'b0;
        sda_nxt  = 1'b0;
      end else begin
        poll_nxt = poll_r + 16'd1;
      end
    end else if (!tick_down) begin
      unique case (phase_r)
        PH_ST_A:   sda_nxt = 1'b0;
        PH_ST_B:   scl_nxt = 1'b0;
        PH_SP_A:   begin scl_nxt = 1'b1; sda_nxt = 1'b1; end
        PH_W_LOW:  scl_nxt = 1'b1;
        PH_W_HIGH: scl_nxt = 1'b0;
        PH_W_TAIL: begin
          bit_nxt = bit_inc;
          if (!last_bit) begin
            sda_nxt = shf_r[7];
            shf_nxt = {shf_r[6:0], 1'b0};
          end
        end
        PH_R_LOW: begin
          scl_nxt = 1'b1;
          shf_nxt = {shf_r[6:0], it.sda};
        end
        PH_R_HIGH: begin
          bit_nxt = bit_inc;
          scl_nxt = 1'b0;
          if (last_bit) begin
            rx_nxt  = shf_r;
            drv_nxt = 1'b1;
            sda_nxt = ~rack_r;
          end
        end
        PH_A_LOW:  scl_nxt = 1'b1;
        PH_A_HIGH: scl_nxt = 1'b0;
        PH_K_PRE:  scl_nxt = 1'b1;
        PH_K_HIGH: poll_nxt = 16'd0;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (step_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r <= TPU_RESET;
      tmo_r <= TMO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TICKS_PER_US: tpu_r <= cfg_data[9:0];
        REG_ACK_TIMEOUT:  tmo_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      dly_r       <= 13'd0;
      bit_r       <= 4'd0;
      shf_r       <= 8'd0;
      poll_r      <= 16'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      drv_r       <= 1'b1;
      rack_r      <= 1'b0;
      rx_r        <= 8'd0;
      nack_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (step_en) begin
        phase_r <= phase_nxt;
        dly_r   <= dly_nxt;
        bit_r   <= bit_nxt;
        shf_r   <= shf_nxt;
        poll_r  <= poll_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        drv_r   <= drv_nxt;
        rack_r  <= rack_nxt;
        rx_r    <= rx_nxt;
        nack_r  <= nack_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_busy_r <= (phase_nxt != PH_IDLE);
      out_done_r <= done_nxt;
      out_rej_r  <= rej_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.scl_out      = scl_r;
  assign out_ch.sda_out      = sda_r;
  assign out_ch.sda_drive    = drv_r;
  assign out_ch.busy_res     = out_busy_r;
  assign out_ch.done_res     = out_done_r;
  assign out_ch.rx_byte      = rx_r;
  assign out_ch.no_ack       = nack_r;
  assign out_ch.cmd_rejected = out_rej_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_done_r && out_busy_r))
    else $error("done and busy reported together");

  a_poll_released: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_K_POLL) |-> (!drv_r && scl_r))
    else $error("ack poll with SDA driven or SCL low");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= BITS_PER_BYTE)
    else $error("bit index out of range");

  a_idle_none: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && is_idle && (it.cmd == CMD_NONE)) |=> (phase_r == PH_IDLE))
    else $error("idle left without a command");

  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && !is_idle && (it.cmd != CMD_NONE)) |=> (out_valid_r && out_rej_r))
    else $error("busy command not flagged as rejected");

endmodule
`default_nettype wire

@@ hdl/i2c_master_bit_engine_core.sv @@
// I2C master bit engine: one input transfer per clock tick of the bus sequence.
//
// in_ch carries one tick per transfer: op, tx_byte, ack_after_read and the
// sampled sda_in. out_ch returns exactly one result per tick with the driven
// SCL/SDA levels, busy/done, the last received byte, no_ack and cmd_rejected.
// cfg_we/cfg_index/cfg_data write ticks_per_us (index 0) and ack_timeout
// (index 1); write them only while no tick is in flight.
// A transferred tick is first written into the queue; the sequencer step then
// registers its result into the output register.
// Throughput: one tick per cycle while out_ch does not stall; the sequencer advances one step per tick.
// Reset: SCL high, SDA high and driven, sequencer idle, ticks_per_us 100,
// ack_timeout 250, queue and output register empty.
// When out_ch stalls, the sequencer holds; the two-entry queue absorbs
// in-flight ticks and in_ch.ready drops once it is full.
`default_nettype none
module i2c_master_bit_engine_core (
  input  logic          clk,
  input  logic          rst_n,
  i2cmbe_in_if.sink     in_ch,
  i2cmbe_out_if.source  out_ch,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  import i2cmbe_pkg::*;

  fe2be_t q_head;
  logic   q_pop;

  i2cmbe_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  i2cmbe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

@@ sim/i2c_master_bit_engine_core_tb.sv @@
// Testbench for the I2C master bit engine: random and directed ticks checked against a line model.
`timescale 1ns / 100ps
module i2c_master_bit_engine_core_tb;
  import i2cmbe_pkg::*;

  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam int SDA_LOW  = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  localparam int NO_ACK_HOLD = 1 << 30;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_AT     = 600;
  localparam int HOLD_LEN    = 60;
  localparam int DRAIN_AT    = 1000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx;
    logic       ack;
    logic       sda;
  } tick_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drv;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       nack;
    logic       rej;
  } line_res_t;

  typedef struct {
    phase_t      phase;
    logic [12:0] dly;
    logic [3:0]  bit_idx;
    logic [7:0]  shreg;
    logic [15:0] polls;
    logic        scl;
    logic        sda;
    logic        drv;
    logic        ack_sel;
    logic [7:0]  rx;
    logic        nack;
    logic        fin;
  } bus_state_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;

  i2cmbe_in_if  in_ch ();
  i2cmbe_out_if out_ch ();

  i2c_master_bit_engine_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [9:0]  tpu_cfg;
  logic [15:0] ack_limit_cfg;
  bus_state_t  bus_plan;
  bus_state_t  bus_model;
  tick_t       tick_q[$];
  line_res_t   line_exp_q[$];
  tick_t       drv_tick;
  line_res_t   got;
  line_res_t   want;
  bit          in_taken;
  bit          drain_done;
  bit          hold_fired;
  int          hold_left;
  int          in_sent;
  int          res_count;
  int          gen_count;
  int          fail_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          ack_hold;
  int          polls_given;

  always #2 clk = ~clk;

  function automatic bus_state_t bus_reset();
    bus_state_t s;
    s.phase   = PH_IDLE;
    s.dly     = '0;
    s.bit_idx = '0;
    s.shreg   = '0;
    s.polls   = '0;
    s.scl     = 1'b1;
    s.sda     = 1'b1;
    s.drv     = 1'b1;
    s.ack_sel = 1'b0;
    s.rx      = '0;
    s.nack    = 1'b0;
    s.fin     = 1'b0;
    return s;
  endfunction

  function automatic logic [12:0] unit_ticks(input logic [2:0] units);
    logic [9:0] t;
    t = (tpu_cfg == 10'd0) ? 10'd1 : tpu_cfg;
    return 13'(units) * 13'(t);
  endfunction

  function automatic void arm(inout bus_state_t s, input logic [2:0] units, input phase_t nxt);
    s.dly   = unit_ticks(units);
    s.phase = nxt;
  endfunction

  function automatic void end_cmd(inout bus_state_t s);
    s.phase = PH_IDLE;
    s.dly   = '0;
    s.fin   = 1'b1;
  endfunction

  function automatic void enter_stop(inout bus_state_t s);
    s.drv = 1'b1;
    s.scl = 1'b0;
    s.sda = 1'b0;
    arm(s, 3'd4, PH_SP_A);
  endfunction

  function automatic void shift_out_bit(inout bus_state_t s);
    s.sda   = s.shreg[7];
    s.shreg = s.shreg << 1;
    arm(s, 3'd2, PH_W_LOW);
  endfunction

  function automatic line_res_t bus_step(inout bus_state_t s, input tick_t it);
    logic rej;
    logic cmd_ok;
    rej    = 1'b0;
    s.fin  = 1'b0;
    cmd_ok = (it.op >= OP_START) && (it.op <= OP_WACK);
    if (s.phase == PH_IDLE) begin
      if (cmd_ok) begin
        case (it.op)
          OP_START: begin
            s.drv = 1'b1;
            s.sda = 1'b1;
            s.scl = 1'b1;
            arm(s, 3'd4, PH_ST_A);
          end
          OP_STOP: enter_stop(s);
          OP_WRITE: begin
            s.drv     = 1'b1;
            s.scl     = 1'b0;
            s.bit_idx = '0;
            s.shreg   = it.tx;
            shift_out_bit(s);
          end
          OP_READ: begin
            s.drv     = 1'b0;
            s.bit_idx = '0;
            s.shreg   = '0;
            s.ack_sel = it.ack;
            s.scl     = 1'b0;
            arm(s, 3'd2, PH_R_LOW);
          end
          default: begin
            s.drv  = 1'b0;
            s.sda  = 1'b1;
            s.nack = 1'b0;
            arm(s, 3'd1, PH_K_PRE);
          end
        endcase
      end
    end else begin
      rej = cmd_ok;
      if (s.phase == PH_K_POLL) begin
        if (!it.sda) begin
          s.scl = 1'b0;
          end_cmd(s);
        end else if (s.polls >= ack_limit_cfg) begin
          s.nack = 1'b1;
          enter_stop(s);
        end else begin
          s.polls = s.polls + 16'd1;
        end
      end else if (s.dly > 13'd1) begin
        s.dly = s.dly - 13'd1;
      end else begin
        case (s.phase)
          PH_ST_A: begin
            s.sda = 1'b0;
            arm(s, 3'd4, PH_ST_B);
          end
          PH_ST_B: begin
            s.scl = 1'b0;
            end_cmd(s);
          end
          PH_SP_A: begin
            s.scl = 1'b1;
            s.sda = 1'b1;
            arm(s, 3'd4, PH_SP_B);
          end
          PH_W_LOW: begin
            s.scl = 1'b1;
            arm(s, 3'd2, PH_W_HIGH);
          end
          PH_W_HIGH: begin
            s.scl = 1'b0;
            arm(s, 3'd2, PH_W_TAIL);
          end
          PH_W_TAIL: begin
            s.bit_idx = s.bit_idx + 4'd1;
            if (s.bit_idx >= BITS_PER_BYTE) end_cmd(s);
            else shift_out_bit(s);
          end
          PH_R_LOW: begin
            s.scl   = 1'b1;
            s.shreg = {s.shreg[6:0], it.sda};
            arm(s, 3'd1, PH_R_HIGH);
          end
          PH_R_HIGH: begin
            s.bit_idx = s.bit_idx + 4'd1;
            s.scl     = 1'b0;
            if (s.bit_idx >= BITS_PER_BYTE) begin
              s.rx  = s.shreg;
              s.drv = 1'b1;
              s.sda = ~s.ack_sel;
              arm(s, 3'd2, PH_A_LOW);
            end else begin
              arm(s, 3'd2, PH_R_LOW);
            end
          end
          PH_A_LOW: begin
            s.scl = 1'b1;
            arm(s, 3'd2, PH_A_HIGH);
          end
          PH_A_HIGH: begin
            s.scl = 1'b0;
            end_cmd(s);
          end
          PH_K_PRE: begin
            s.scl = 1'b1;
            arm(s, 3'd1, PH_K_HIGH);
          end
          PH_K_HIGH: begin
            s.polls = '0;
            s.dly   = '0;
            s.phase = PH_K_POLL;
          end
          default: end_cmd(s);
        endcase
      end
    end
    return {s.scl, s.sda, s.drv, s.phase != PH_IDLE, s.fin, s.rx, s.nack, rej};
  endfunction

  task automatic log_failure(input string what);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("%0t: %s", $realtime, what);
  endtask

  function automatic string fmt_res(input line_res_t r);
    return $sformatf("scl=%b sda=%b drv=%b busy=%b done=%b rx=%h nack=%b rej=%b",
                     r.scl, r.sda, r.drv, r.busy, r.done, r.rx, r.nack, r.rej);
  endfunction

  task automatic push_tick(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                           input logic sda);
    tick_t t;
    t.op  = op;
    t.tx  = tx;
    t.ack = ack;
    t.sda = sda;
    void'(bus_step(bus_plan, t));
    tick_q.push_back(t);
    gen_count++;
  endtask

  function automatic int pick_hold();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, 2);
    if (r < 7) return int'(ack_limit_cfg);
    return NO_ACK_HOLD;
  endfunction

  task automatic run_cmd(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                         input int hold, input int noise_pct, input int sda_mode);
    bus_state_t probe;
    tick_t      probe_in;
    line_res_t  pr;
    logic [2:0] bop;
    logic       sda;
    ack_hold    = hold;
    polls_given = 0;
    push_tick(op, tx, ack, 1'($urandom_range(0, 1)));
    while (bus_plan.phase != PH_IDLE) begin
      if (bus_plan.phase == PH_K_POLL) begin
        sda = (polls_given < ack_hold);
        polls_given++;
      end else if (sda_mode == SDA_RAND) begin
        sda = 1'($urandom_range(0, 1));
      end else begin
        sda = (sda_mode == SDA_HIGH);
      end
      probe    = bus_plan;
      probe_in = {OP_NONE, 8'h00, 1'b0, sda};
      pr       = bus_step(probe, probe_in);
      bop      = OP_NONE;
      if ((pr.done && $urandom_range(0, 99) < 30) || $urandom_range(0, 99) < noise_pct)
        bop = 3'($urandom_range(1, 7));
      push_tick(bop, 8'($urandom), 1'($urandom_range(0, 1)), sda);
    end
    repeat ($urandom_range(0, 2))
      push_tick(OP_NONE, 8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic random_traffic(input int n);
    int stop_at;
    int k;
    stop_at = gen_count + n;
    while (gen_count < stop_at) begin
      if ($urandom_range(0, 99) < 15) begin
        run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)), pick_hold(),
                10, SDA_RAND);
      end else begin
        run_cmd(OP_START, 8'($urandom), 1'($urandom_range(0, 1)), 0, 5, SDA_RAND);
        run_cmd(OP_WRITE, 8'($urandom), 1'($urandom_range(0, 1)), 0, 5, SDA_RAND);
        run_cmd(OP_WACK, 8'($urandom), 1'($urandom_range(0, 1)), pick_hold(), 5, SDA_RAND);
        k = $urandom_range(1, 3);
        repeat (k) begin
          if ($urandom_range(0, 1)) begin
            run_cmd(OP_WRITE, 8'($urandom), 1'($urandom_range(0, 1)), 0, 5, SDA_RAND);
            run_cmd(OP_WACK, 8'($urandom), 1'($urandom_range(0, 1)), pick_hold(), 5,
                    SDA_RAND);
          end else begin
            run_cmd(OP_READ, 8'($urandom), 1'($urandom_range(0, 1)), 0, 5, SDA_RAND);
          end
        end
        run_cmd(OP_STOP, 8'($urandom), 1'($urandom_range(0, 1)), 0, 5, SDA_RAND);
      end
    end
  endtask

  task automatic drain_all();
    while (tick_q.size() != 0 || in_ch.valid || line_exp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [15:0] tpu_word, input logic [15:0] tmo_word);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TICKS_PER_US;
    cfg_data  <= tpu_word;
    @(negedge clk);
    cfg_index <= REG_ACK_TIMEOUT;
    cfg_data  <= tmo_word;
    @(negedge clk);
    cfg_we    <= 1'b0;
    tpu_cfg       = tpu_word[9:0];
    ack_limit_cfg = tmo_word;
  endtask

  // input side: record transfers and predict their results
  always @(posedge clk) begin
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      drv_tick = {in_ch.op, in_ch.tx_byte, in_ch.ack_after_read, in_ch.sda_in};
      line_exp_q.push_back(bus_step(bus_model, drv_tick));
      in_sent++;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (in_sent == DRAIN_AT && !drain_done && line_exp_q.size() == 0) drain_done = 1'b1;
      if (tick_q.size() != 0 && !(in_sent == DRAIN_AT && !drain_done) &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        drv_tick = tick_q.pop_front();
        in_ch.valid          <= 1'b1;
        in_ch.op             <= drv_tick.op;
        in_ch.tx_byte        <= drv_tick.tx;
        in_ch.ack_after_read <= drv_tick.ack;
        in_ch.sda_in         <= drv_tick.sda;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off to fill the block and stall its input
  always @(posedge clk) begin
    if (!hold_fired && res_count >= HOLD_AT) begin
      hold_left  = HOLD_LEN;
      hold_fired = 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.scl_out, out_ch.sda_out, out_ch.sda_drive, out_ch.busy_res,
             out_ch.done_res, out_ch.rx_byte, out_ch.no_ack, out_ch.cmd_rejected};
      res_count++;
      if (line_exp_q.size() == 0) begin
        log_failure({"result with nothing expected: ", fmt_res(got)});
      end else begin
        want = line_exp_q.pop_front();
        if (got !== want)
          log_failure($sformatf("result %0d mismatch\n  exp %s\n  got %s", res_count,
                                fmt_res(want), fmt_res(got)));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.op             = OP_NONE;
    in_ch.tx_byte        = 8'h00;
    in_ch.ack_after_read = 1'b0;
    in_ch.sda_in         = 1'b1;
    out_ch.ready         = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = REG_TICKS_PER_US;
    cfg_data             = 16'h0000;
    tpu_cfg              = TPU_RESET;
    ack_limit_cfg        = TMO_RESET;
    bus_plan             = bus_reset();
    bus_model            = bus_reset();
    in_taken             = 1'b0;
    drain_done           = 1'b0;
    hold_fired           = 1'b0;
    hold_left            = 0;
    in_sent              = 0;
    res_count            = 0;
    gen_count            = 0;
    fail_count           = 0;
    cycle_count          = 0;
    send_idle_pct        = 18;
    recv_idle_pct        = 62;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset delays and timeout: ack arrives on the last tolerated poll
    run_cmd(OP_WACK, 8'h00, 1'b0, int'(TMO_RESET), 0, SDA_RAND);
    drain_all();

    write_cfg(16'hFC01, 16'd3);
    run_cmd(OP_START, 8'h00, 1'b0, 0, 0, SDA_RAND);
    run_cmd(OP_WRITE, 8'hFF, 1'b0, 0, 0, SDA_HIGH);
    run_cmd(OP_WACK, 8'h00, 1'b0, 0, 0, SDA_RAND);
    run_cmd(OP_WRITE, 8'h00, 1'b1, 0, 0, SDA_LOW);
    run_cmd(OP_WACK, 8'hFF, 1'b1, 3, 0, SDA_RAND);
    run_cmd(OP_WRITE, 8'hA5, 1'b0, 0, 25, SDA_RAND);
    run_cmd(OP_WACK, 8'h00, 1'b0, NO_ACK_HOLD, 0, SDA_RAND);
    run_cmd(OP_READ, 8'h00, 1'b1, 0, 0, SDA_HIGH);
    run_cmd(OP_READ, 8'hFF, 1'b0, 0, 0, SDA_LOW);
    run_cmd(OP_READ, 8'h5A, 1'b1, 0, 25, SDA_RAND);
    run_cmd(OP_RSVD6, 8'hFF, 1'b1, 0, 0, SDA_RAND);
    run_cmd(OP_RSVD7, 8'h00, 1'b0, 0, 0, SDA_RAND);
    run_cmd(OP_STOP, 8'h00, 1'b0, 0, 0, SDA_RAND);
    run_cmd(OP_NONE, 8'h00, 1'b0, 0, 0, SDA_RAND);
    random_traffic(200);
    drain_all();

    write_cfg(16'd0, 16'd0);
    random_traffic(150);
    drain_all();

    send_idle_pct = 62;
    recv_idle_pct = 18;
    write_cfg(16'd2, 16'd5);
    random_traffic(200);
    drain_all();

    write_cfg(16'd3, 16'd1);
    random_traffic(150);
    drain_all();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_cfg(16'd37, 16'd65535);
    run_cmd(OP_WACK, 8'h3C, 1'b0, 0, 0, SDA_RAND);
    drain_all();

    write_cfg(16'd1, 16'd65535);
    run_cmd(OP_WACK, 8'h00, 1'b0, 40, 0, SDA_RAND);
    drain_all();

    write_cfg(16'd1, 16'd2);
    random_traffic(100);
    drain_all();

    repeat (8) @(posedge clk);
    if (line_exp_q.size() != 0) log_failure("expected results still pending at end");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/i2cmbe_pkg.sv
hdl/i2cmbe_ifs.sv
hdl/i2cmbe_front.sv
hdl/i2cmbe_back.sv
hdl/i2c_master_bit_engine_core.sv
sim/i2c_master_bit_engine_core_tb.sv
